/* src/cia_pkg.sv */
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types and constants for the complex integer ALU pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cia_pkg;

  localparam int OPERAND_BITS_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int OUT_BITS          = 49;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cia_op_t;

  // Side information that travels with an item through the divider stages.
  typedef struct packed {
    logic                       is_div;
    logic                       dz;
    logic                       neg_re;
    logic                       neg_im;
    logic signed [OUT_BITS-1:0] pre_re;
    logic signed [OUT_BITS-1:0] pre_im;
  } cia_tag_t;

endpackage : cia_pkg

`default_nettype wire

/* src/cia_front.sv */
// ----------------------------------------------------------------------------
// cia_front
// Two register stages: partial products, then sums, magnitudes and divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module cia_front #(
  parameter int OPERAND_BITS  = cia_pkg::OPERAND_BITS_DEF,
  parameter int FRACTION_BITS = cia_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           vld_i,
  input  wire logic [1:0]                     op_i,
  input  wire logic signed [OPERAND_BITS-1:0] a_re_i,
  input  wire logic signed [OPERAND_BITS-1:0] a_im_i,
  input  wire logic signed [OPERAND_BITS-1:0] b_re_i,
  input  wire logic signed [OPERAND_BITS-1:0] b_im_i,
  output logic                                vld_o,
  output cia_pkg::cia_tag_t                   tag_o,
  output logic [2*OPERAND_BITS-1:0]           den_o,
  output logic [2*OPERAND_BITS+FRACTION_BITS-1:0] nq_re_o,
  output logic [2*OPERAND_BITS+FRACTION_BITS-1:0] nq_im_o
);
  import cia_pkg::*;

  localparam int W  = OPERAND_BITS;
  localparam int DW = 2 * OPERAND_BITS;
  localparam int QW = 2 * OPERAND_BITS + FRACTION_BITS;

  // Stage 1: products and linear results
  logic                   vld1_r;
  cia_op_t                op1_r;
  logic                   dz1_r;
  logic signed [DW-1:0]   p_rr_r, p_ii_r, p_ri_r, p_ir_r, sq_r_r, sq_i_r;
  logic signed [W:0]      sum_re_r, sum_im_r, dif_re_r, dif_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    op1_r    <= cia_op_t'(op_i);
    dz1_r    <= (b_re_i == '0) && (b_im_i == '0);
    p_rr_r   <= a_re_i * b_re_i;
    p_ii_r   <= a_im_i * b_im_i;
    p_ri_r   <= a_re_i * b_im_i;
    p_ir_r   <= a_im_i * b_re_i;
    sq_r_r   <= b_re_i * b_re_i;
    sq_i_r   <= b_im_i * b_im_i;
    sum_re_r <= (W+1)'(a_re_i) + (W+1)'(b_re_i);
    sum_im_r <= (W+1)'(a_im_i) + (W+1)'(b_im_i);
    dif_re_r <= (W+1)'(a_re_i) - (W+1)'(b_re_i);
    dif_im_r <= (W+1)'(a_im_i) - (W+1)'(b_im_i);
  end

  // Stage 2: combine products, take magnitudes of the dividends
  logic signed [DW:0] mul_re, mul_im, num_re, num_im;
  logic [DW-1:0]      mag_re, mag_im;
  cia_tag_t           tag_nxt;

  always_comb begin
    mul_re = (DW+1)'(p_rr_r) - (DW+1)'(p_ii_r);
    mul_im = (DW+1)'(p_ri_r) + (DW+1)'(p_ir_r);
    num_re = (DW+1)'(p_rr_r) + (DW+1)'(p_ii_r);
    num_im = (DW+1)'(p_ir_r) - (DW+1)'(p_ri_r);
    mag_re = num_re[DW] ? DW'(-num_re) : DW'(num_re);
    mag_im = num_im[DW] ? DW'(-num_im) : DW'(num_im);

    tag_nxt.is_div = (op1_r == OP_DIV);
    tag_nxt.dz     = (op1_r == OP_DIV) && dz1_r;
    tag_nxt.neg_re = num_re[DW];
    tag_nxt.neg_im = num_im[DW];
    unique case (op1_r)
      OP_ADD: begin
        tag_nxt.pre_re = OUT_BITS'(sum_re_r);
        tag_nxt.pre_im = OUT_BITS'(sum_im_r);
      end
      OP_SUB: begin
        tag_nxt.pre_re = OUT_BITS'(dif_re_r);
        tag_nxt.pre_im = OUT_BITS'(dif_im_r);
      end
      default: begin
        tag_nxt.pre_re = OUT_BITS'(mul_re);
        tag_nxt.pre_im = OUT_BITS'(mul_im);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    tag_o   <= tag_nxt;
    den_o   <= DW'($unsigned(sq_r_r)) + DW'($unsigned(sq_i_r));
    nq_re_o <= QW'(mag_re) << FRACTION_BITS;
    nq_im_o <= QW'(mag_im) << FRACTION_BITS;
  end

endmodule : cia_front

`default_nettype wire

/* src/cia_div_step.sv */
// ----------------------------------------------------------------------------
// cia_div_step
// One restoring division step for both quotient lanes, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cia_div_step #(
  parameter int DW = 2 * cia_pkg::OPERAND_BITS_DEF,
  parameter int QW = 2 * cia_pkg::OPERAND_BITS_DEF + cia_pkg::FRACTION_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              vld_i,
  input  wire cia_pkg::cia_tag_t tag_i,
  input  wire logic [DW-1:0]     den_i,
  input  wire logic [DW-1:0]     rem_re_i,
  input  wire logic [QW-1:0]     nq_re_i,
  input  wire logic [DW-1:0]     rem_im_i,
  input  wire logic [QW-1:0]     nq_im_i,
  output logic                   vld_o,
  output cia_pkg::cia_tag_t      tag_o,
  output logic [DW-1:0]          den_o,
  output logic [DW-1:0]          rem_re_o,
  output logic [QW-1:0]          nq_re_o,
  output logic [DW-1:0]          rem_im_o,
  output logic [QW-1:0]          nq_im_o
);
  import cia_pkg::*;

  logic [DW:0]   trial_re, trial_im, diff_re, diff_im;
  logic          ge_re, ge_im;
  logic [DW-1:0] rem_re_nxt, rem_im_nxt;

  // Bring down the next dividend bit, subtract if the divisor fits
  always_comb begin
    trial_re   = {rem_re_i, nq_re_i[QW-1]};
    trial_im   = {rem_im_i, nq_im_i[QW-1]};
    diff_re    = trial_re - {1'b0, den_i};
    diff_im    = trial_im - {1'b0, den_i};
    ge_re      = trial_re >= {1'b0, den_i};
    ge_im      = trial_im >= {1'b0, den_i};
    rem_re_nxt = ge_re ? diff_re[DW-1:0] : trial_re[DW-1:0];
    rem_im_nxt = ge_im ? diff_im[DW-1:0] : trial_im[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    tag_o    <= tag_i;
    den_o    <= den_i;
    rem_re_o <= rem_re_nxt;
    rem_im_o <= rem_im_nxt;
    nq_re_o  <= {nq_re_i[QW-2:0], ge_re};
    nq_im_o  <= {nq_im_i[QW-2:0], ge_im};
  end

endmodule : cia_div_step

`default_nettype wire

/* src/complex_integer_alu.sv */
// ----------------------------------------------------------------------------
// complex_integer_alu
// Pipelined complex add, subtract, multiply and fixed-point divide.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------
//  input    | start / busy       | in_req_type, in_a_re/im, in_b_re/im
//  result   | out_valid (strobe) | out_res_re, out_res_im, out_div_by_zero
//
//  One item is taken every cycle; busy stays low.
//  The pipeline has two front stages (products, then sums and divisor),
//  one restoring division step per quotient bit, and one output stage.
//  Every operation runs the same length so results leave in order.
//  Reset clears only the valid bits and out_div_by_zero; payload registers are not reset.
//  The receiver cannot stall, so nothing holds the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_integer_alu #(
  parameter int OPERAND_BITS  = cia_pkg::OPERAND_BITS_DEF,
  parameter int FRACTION_BITS = cia_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_req_type,
  input  wire logic signed [OPERAND_BITS-1:0] in_a_re,
  input  wire logic signed [OPERAND_BITS-1:0] in_a_im,
  input  wire logic signed [OPERAND_BITS-1:0] in_b_re,
  input  wire logic signed [OPERAND_BITS-1:0] in_b_im,
  output logic                                out_valid,
  output logic signed [cia_pkg::OUT_BITS-1:0] out_res_re,
  output logic signed [cia_pkg::OUT_BITS-1:0] out_res_im,
  output logic                                out_div_by_zero
);
  import cia_pkg::*;

  localparam int DW = 2 * OPERAND_BITS;
  localparam int QW = 2 * OPERAND_BITS + FRACTION_BITS;

  // Never back-pressure the sender
  assign busy = 1'b0;

  // Stage chain: index 0 is the front output, index QW the last divider step
  logic          vld_s    [QW+1];
  cia_tag_t      tag_s    [QW+1];
  logic [DW-1:0] den_s    [QW+1];
  logic [DW-1:0] rem_re_s [QW+1];
  logic [DW-1:0] rem_im_s [QW+1];
  logic [QW-1:0] nq_re_s  [QW+1];
  logic [QW-1:0] nq_im_s  [QW+1];

  cia_front #(
    .OPERAND_BITS  (OPERAND_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (start && !busy),
    .op_i    (in_req_type),
    .a_re_i  (in_a_re),
    .a_im_i  (in_a_im),
    .b_re_i  (in_b_re),
    .b_im_i  (in_b_im),
    .vld_o   (vld_s[0]),
    .tag_o   (tag_s[0]),
    .den_o   (den_s[0]),
    .nq_re_o (nq_re_s[0]),
    .nq_im_o (nq_im_s[0])
  );

  // Partial remainders start empty
  assign rem_re_s[0] = '0;
  assign rem_im_s[0] = '0;

  // One quotient bit per stage, most significant first
  for (genvar i = 0; i < QW; i++) begin : g_div
    cia_div_step #(
      .DW (DW),
      .QW (QW)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .vld_i    (vld_s[i]),
      .tag_i    (tag_s[i]),
      .den_i    (den_s[i]),
      .rem_re_i (rem_re_s[i]),
      .nq_re_i  (nq_re_s[i]),
      .rem_im_i (rem_im_s[i]),
      .nq_im_i  (nq_im_s[i]),
      .vld_o    (vld_s[i+1]),
      .tag_o    (tag_s[i+1]),
      .den_o    (den_s[i+1]),
      .rem_re_o (rem_re_s[i+1]),
      .nq_re_o  (nq_re_s[i+1]),
      .rem_im_o (rem_im_s[i+1]),
      .nq_im_o  (nq_im_s[i+1])
    );
  end

  // Output stage: apply quotient signs, pick divide or pass-through result
  cia_tag_t            tag_l;
  logic signed [QW:0]  q_re, q_im;
  logic signed [OUT_BITS-1:0] res_re_nxt, res_im_nxt;
  logic                dz_nxt;

  always_comb begin
    tag_l = tag_s[QW];
    q_re  = tag_l.neg_re ? -$signed({1'b0, nq_re_s[QW]}) : $signed({1'b0, nq_re_s[QW]});
    q_im  = tag_l.neg_im ? -$signed({1'b0, nq_im_s[QW]}) : $signed({1'b0, nq_im_s[QW]});
    dz_nxt = vld_s[QW] && tag_l.dz;
    priority if (tag_l.dz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
    end else if (tag_l.is_div) begin
      res_re_nxt = OUT_BITS'(q_re);
      res_im_nxt = OUT_BITS'(q_im);
    end else begin
      res_re_nxt = tag_l.pre_re;
      res_im_nxt = tag_l.pre_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid       <= 1'b0;
      out_div_by_zero <= 1'b0;
    end else begin
      out_valid       <= vld_s[QW];
      out_div_by_zero <= dz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_re <= res_re_nxt;
    out_res_im <= res_im_nxt;
  end

`ifndef NO_ASSERTIONS
  // Zero-divisor flag only rides on a delivered result
  a_dz_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_div_by_zero |-> out_valid)
    else $error("div_by_zero without out_valid");

  // Zero-divisor results carry zero parts
  a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_div_by_zero |-> (out_res_re == '0) && (out_res_im == '0))
    else $error("div_by_zero with nonzero parts");

  // Nothing is ever held off at the input
  a_no_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("busy asserted");
`endif

endmodule : complex_integer_alu

`default_nettype wire

/* test/complex_integer_alu_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_integer_alu_tb
// Drives directed and random complex operations into the ALU and checks every
// result strobe against an in-order queue of predicted results.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_integer_alu_tb;
  import cia_pkg::*;

  localparam int OB = OPERAND_BITS_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam int LATENCY = 2 * OB + FB + 3;
  localparam logic signed [OB-1:0] VMAX = 16'sh7fff;
  localparam logic signed [OB-1:0] VMIN = 16'sh8000;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] re;
    logic signed [OUT_BITS-1:0] im;
    logic                       dz;
  } alu_res_t;

  typedef struct {
    cia_op_t              op;
    logic signed [OB-1:0] ar, ai, br, bi;
    logic                 has_exp;  // typed-in expectation present
    alu_res_t             exp_res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = '0;
  logic signed [OB-1:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic out_valid;
  logic signed [OUT_BITS-1:0] out_res_re, out_res_im;
  logic out_div_by_zero;

  alu_res_t  pending_results[$];
  int        error_count = 0;
  stim_row_t dir_rows[$];

  complex_integer_alu dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_a_re(in_a_re), .in_a_im(in_a_im),
    .in_b_re(in_b_re), .in_b_im(in_b_im), .out_valid(out_valid),
    .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_div_by_zero(out_div_by_zero)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Fixed-point quotient num * 2^FB / den, truncated toward zero.
  function automatic logic signed [OUT_BITS-1:0] fx_quotient(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FB) / den;
    return (num < 0) ? OUT_BITS'(-q) : OUT_BITS'(q);
  endfunction

  function automatic alu_res_t predict_complex(cia_op_t op, logic signed [OB-1:0] ar,
      logic signed [OB-1:0] ai, logic signed [OB-1:0] br, logic signed [OB-1:0] bi);
    alu_res_t r;
    longint a, b, c, d, den;
    a = ar; b = ai; c = br; d = bi;
    r = '0;
    case (op)
      OP_ADD: begin r.re = OUT_BITS'(a + c); r.im = OUT_BITS'(b + d); end
      OP_SUB: begin r.re = OUT_BITS'(a - c); r.im = OUT_BITS'(b - d); end
      OP_MUL: begin
        r.re = OUT_BITS'(a * c - b * d);
        r.im = OUT_BITS'(a * d + b * c);
      end
      default: begin
        if (c == 0 && d == 0) begin
          r.dz = 1'b1;
        end else begin
          den = c * c + d * d;
          r.re = fx_quotient(a * c + b * d, den);
          r.im = fx_quotient(b * c - a * d, den);
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Compare each strobe with the oldest expectation.
  always @(posedge clk) begin
    alu_res_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_res_re, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_res_re !== e.re) report_mismatch("res_re", out_res_re, e.re);
        if (out_res_im !== e.im) report_mismatch("res_im", out_res_im, e.im);
        if (out_div_by_zero !== e.dz) report_mismatch("div_by_zero", out_div_by_zero, e.dz);
      end
    end
  end

  function automatic stim_row_t mk_row(cia_op_t op, logic signed [OB-1:0] ar,
      logic signed [OB-1:0] ai, logic signed [OB-1:0] br, logic signed [OB-1:0] bi,
      logic has, alu_res_t er);
    stim_row_t s;
    s.op = op; s.ar = ar; s.ai = ai; s.br = br; s.bi = bi;
    s.has_exp = has; s.exp_res = er;
    return s;
  endfunction

  // Hold start for one transfer, then wait for it to be taken.
  task automatic send_item(cia_op_t op, logic signed [OB-1:0] ar, logic signed [OB-1:0] ai,
      logic signed [OB-1:0] br, logic signed [OB-1:0] bi, logic has, alu_res_t er,
      bit idle_on);
    if (idle_on) begin
      while ($urandom_range(99) < 11) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_req_type <= op;
    in_a_re <= ar; in_a_im <= ai; in_b_re <= br; in_b_im <= bi;
    do @(posedge clk); while (busy);
    pending_results.push_back(has ? er : predict_complex(op, ar, ai, br, bi));
  endtask

  function automatic logic signed [OB-1:0] rand_operand();
    case ($urandom_range(7))
      0: return VMAX;
      1: return VMIN;
      2: return OB'($urandom_range(7) - 3);
      default: return OB'($urandom);
    endcase
  endfunction

  initial begin
    alu_res_t z;
    alu_res_t dz_res;
    stim_row_t s;
    int wait_cycles;
    z = '0;
    dz_res = '0; dz_res.dz = 1'b1;
    // Extremes, every operation, zero divisor and both truncation signs.
    dir_rows.push_back(mk_row(OP_ADD, '0, '0, '0, '0, 1'b1, z));
    dir_rows.push_back(mk_row(OP_ADD, VMAX, VMAX, VMAX, VMAX, 1'b1, '{65534, 65534, 0}));
    dir_rows.push_back(mk_row(OP_ADD, VMIN, VMIN, VMIN, VMIN, 1'b1, '{-65536, -65536, 0}));
    dir_rows.push_back(mk_row(OP_SUB, VMAX, VMIN, VMIN, VMAX, 1'b1, '{65535, -65535, 0}));
    dir_rows.push_back(mk_row(OP_SUB, VMIN, VMAX, VMAX, VMIN, 1'b0, z));
    dir_rows.push_back(mk_row(OP_MUL, VMIN, VMIN, VMIN, VMIN, 1'b0, z));
    dir_rows.push_back(mk_row(OP_MUL, VMIN, VMAX, VMAX, VMIN, 1'b0, z));
    dir_rows.push_back(mk_row(OP_MUL, VMAX, VMAX, VMAX, VMAX, 1'b0, z));
    dir_rows.push_back(mk_row(OP_DIV, 16'sd5, -16'sd7, '0, '0, 1'b1, dz_res));
    dir_rows.push_back(mk_row(OP_DIV, VMIN, VMIN, '0, '0, 1'b1, dz_res));
    dir_rows.push_back(mk_row(OP_DIV, 16'sd1, '0, 16'sd1, '0, 1'b1, '{65536, 0, 0}));
    dir_rows.push_back(mk_row(OP_DIV, VMIN, VMIN, 16'sd1, '0, 1'b0, z));
    dir_rows.push_back(mk_row(OP_DIV, VMIN, VMAX, VMIN, VMIN, 1'b0, z));
    dir_rows.push_back(mk_row(OP_DIV, 16'sd1, 16'sd1, 16'sd3, '0, 1'b0, z));
    dir_rows.push_back(mk_row(OP_DIV, -16'sd1, -16'sd1, 16'sd3, '0, 1'b0, z));
    dir_rows.push_back(mk_row(OP_DIV, 16'sd1, VMAX, VMAX, VMIN, 1'b0, z));
    dir_rows.push_back(mk_row(OP_DIV, VMAX, VMIN, '0, -16'sd1, 1'b0, z));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      s = dir_rows[i];
      send_item(s.op, s.ar, s.ai, s.br, s.bi, s.has_exp, s.exp_res, 1'b0);
    end
    // Random part; items 150..299 run back to back with no idling.
    for (int n = 0; n < 500; n++) begin
      send_item(cia_op_t'($urandom_range(3)), rand_operand(), rand_operand(),
                rand_operand(), rand_operand(), 1'b0, z, !(n >= 150 && n < 300));
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 10 * LATENCY) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Drop the run if it hangs.
  initial begin
    #200000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
